// ===== rtl/sit_pkg.sv =====
`default_nettype none

package sit_pkg;

   // Coordinate width and the exact widths that follow from it
   localparam int COORD_WIDTH = 16;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int BOUND_W     = DIFF_W + CROSS_W;

   // Register stages between the request and the response port
   localparam int PIPE_DEPTH  = 6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [CROSS_W-1:0]     cross_type;
   typedef logic signed [BOUND_W-1:0]     bound_type;

   // Endpoints of both segments as one word
   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
      coord_type c_x;
      coord_type c_y;
      coord_type d_x;
      coord_type d_y;
   } seg_type;

   // Box corners of both segments, relative to point A
   typedef struct packed {
      diff_type a_lo_x;
      diff_type a_hi_x;
      diff_type c_lo_x;
      diff_type c_hi_x;
      diff_type a_lo_y;
      diff_type a_hi_y;
      diff_type c_lo_y;
      diff_type c_hi_y;
   } box_type;

   // Determinant, intersection numerator and what the bound checks still need
   typedef struct packed {
      diff_type  rx;
      diff_type  ry;
      cross_type den;
      cross_type tn;
      box_type   box;
   } xprod_type;

endpackage

`default_nettype wire

// ===== rtl/sit_if.sv =====
`default_nettype none

// Request channel: one segment pair per word
interface sit_req_if import sit_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type a_x;
   coord_type a_y;
   coord_type b_x;
   coord_type b_y;
   coord_type c_x;
   coord_type c_y;
   coord_type d_x;
   coord_type d_y;

   modport source (output valid, input ready,
                   output a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y);
   modport sink   (input valid, output ready,
                   input a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y);
endinterface

// Response channel: verdict for one segment pair per word
interface sit_rsp_if import sit_pkg::*; ();
   logic valid;
   logic ready;
   logic hit;
   logic parallel;

   modport source (output valid, input ready, output hit, parallel);
   modport sink   (input valid, output ready, input hit, parallel);
endinterface

`default_nettype wire

// ===== rtl/sit_cross.sv =====
`default_nettype none

// Stages one to three: differences and box corners, cross products,
// determinant and intersection numerator.
module sit_cross import sit_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  seg_type   seg,
   output logic      out_valid,
   input  logic      out_ready,
   output xprod_type xprod
);

   typedef struct packed {
      diff_type rx;
      diff_type ry;
      diff_type sx;
      diff_type sy;
      diff_type qx;
      diff_type qy;
      box_type  box;
   } diffs_type;

   typedef struct packed {
      diff_type rx;
      diff_type ry;
      prod_type rx_sy;
      prod_type ry_sx;
      prod_type qx_sy;
      prod_type qy_sx;
      box_type  box;
   } prods_type;

   function automatic diff_type sub_c(coord_type p, coord_type q);
      return DIFF_W'(p) - DIFF_W'(q);
   endfunction

   function automatic coord_type min_c(coord_type p, coord_type q);
      return (p < q) ? p : q;
   endfunction

   function automatic coord_type max_c(coord_type p, coord_type q);
      return (p < q) ? q : p;
   endfunction

   function automatic prod_type mul_d(diff_type p, diff_type q);
      return PROD_W'(p) * PROD_W'(q);
   endfunction

   logic      v1_ff, v2_ff, v3_ff;
   logic      rdy1, rdy2, rdy3;
   diffs_type s1_in, s1_ff;
   prods_type s2_in, s2_ff;
   xprod_type s3_in, s3_ff;

   // Advance a stage when it is empty or its successor moves
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage one: direction vectors, offset of C, box corners against A
   always_comb begin
      s1_in.rx         = sub_c(seg.b_x, seg.a_x);
      s1_in.ry         = sub_c(seg.b_y, seg.a_y);
      s1_in.sx         = sub_c(seg.d_x, seg.c_x);
      s1_in.sy         = sub_c(seg.d_y, seg.c_y);
      s1_in.qx         = sub_c(seg.c_x, seg.a_x);
      s1_in.qy         = sub_c(seg.c_y, seg.a_y);
      s1_in.box.a_lo_x = sub_c(min_c(seg.a_x, seg.b_x), seg.a_x);
      s1_in.box.a_hi_x = sub_c(max_c(seg.a_x, seg.b_x), seg.a_x);
      s1_in.box.c_lo_x = sub_c(min_c(seg.c_x, seg.d_x), seg.a_x);
      s1_in.box.c_hi_x = sub_c(max_c(seg.c_x, seg.d_x), seg.a_x);
      s1_in.box.a_lo_y = sub_c(min_c(seg.a_y, seg.b_y), seg.a_y);
      s1_in.box.a_hi_y = sub_c(max_c(seg.a_y, seg.b_y), seg.a_y);
      s1_in.box.c_lo_y = sub_c(min_c(seg.c_y, seg.d_y), seg.a_y);
      s1_in.box.c_hi_y = sub_c(max_c(seg.c_y, seg.d_y), seg.a_y);
   end

   // Stage two: the four cross-product terms
   always_comb begin
      s2_in.rx    = s1_ff.rx;
      s2_in.ry    = s1_ff.ry;
      s2_in.rx_sy = mul_d(s1_ff.rx, s1_ff.sy);
      s2_in.ry_sx = mul_d(s1_ff.ry, s1_ff.sx);
      s2_in.qx_sy = mul_d(s1_ff.qx, s1_ff.sy);
      s2_in.qy_sx = mul_d(s1_ff.qy, s1_ff.sx);
      s2_in.box   = s1_ff.box;
   end

   // Stage three: determinant and numerator of the line parameter
   always_comb begin
      s3_in.rx  = s2_ff.rx;
      s3_in.ry  = s2_ff.ry;
      s3_in.den = CROSS_W'(s2_ff.rx_sy) - CROSS_W'(s2_ff.ry_sx);
      s3_in.tn  = CROSS_W'(s2_ff.qx_sy) - CROSS_W'(s2_ff.qy_sx);
      s3_in.box = s2_ff.box;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Payload, held while the stage stalls
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign xprod     = s3_ff;

endmodule

`default_nettype wire

// ===== rtl/sit_bound.sv =====
`default_nettype none

// Stages four to six: sign fold of the determinant, scaled box bounds and
// intersection numerators, then the inclusive bound compares.
module sit_bound import sit_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  xprod_type xprod,
   output logic      out_valid,
   input  logic      out_ready,
   output logic      hit,
   output logic      parallel
);

   typedef struct packed {
      logic      par;
      diff_type  rx;
      diff_type  ry;
      cross_type den_abs;
      cross_type tn_adj;
      box_type   box;
   } fold_type;

   typedef struct packed {
      logic      par;
      bound_type nx;
      bound_type ny;
      bound_type a_lo_x;
      bound_type a_hi_x;
      bound_type c_lo_x;
      bound_type c_hi_x;
      bound_type a_lo_y;
      bound_type a_hi_y;
      bound_type c_lo_y;
      bound_type c_hi_y;
   } scaled_type;

   function automatic bound_type mul_b(diff_type p, cross_type q);
      return BOUND_W'(p) * BOUND_W'(q);
   endfunction

   function automatic logic in_span(bound_type lo, bound_type num, bound_type hi);
      return ($signed(lo) <= $signed(num)) && ($signed(num) <= $signed(hi));
   endfunction

   logic       v4_ff, v5_ff, v6_ff;
   logic       rdy4, rdy5, rdy6;
   logic       den_neg;
   fold_type   s4_in, s4_ff;
   scaled_type s5_in, s5_ff;
   logic       hit_in, hit_ff;
   logic       par_ff;

   // Advance a stage when it is empty or its successor moves
   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   // Stage four: make the determinant positive, flip the numerator with it
   assign den_neg = xprod.den[CROSS_W-1];

   always_comb begin
      s4_in.par     = (xprod.den == '0);
      s4_in.rx      = xprod.rx;
      s4_in.ry      = xprod.ry;
      s4_in.den_abs = den_neg ? -xprod.den : xprod.den;
      s4_in.tn_adj  = den_neg ? -xprod.tn : xprod.tn;
      s4_in.box     = xprod.box;
   end

   // Stage five: numerators of the crossing point and bounds scaled by the determinant
   always_comb begin
      s5_in.par    = s4_ff.par;
      s5_in.nx     = mul_b(s4_ff.rx, s4_ff.tn_adj);
      s5_in.ny     = mul_b(s4_ff.ry, s4_ff.tn_adj);
      s5_in.a_lo_x = mul_b(s4_ff.box.a_lo_x, s4_ff.den_abs);
      s5_in.a_hi_x = mul_b(s4_ff.box.a_hi_x, s4_ff.den_abs);
      s5_in.c_lo_x = mul_b(s4_ff.box.c_lo_x, s4_ff.den_abs);
      s5_in.c_hi_x = mul_b(s4_ff.box.c_hi_x, s4_ff.den_abs);
      s5_in.a_lo_y = mul_b(s4_ff.box.a_lo_y, s4_ff.den_abs);
      s5_in.a_hi_y = mul_b(s4_ff.box.a_hi_y, s4_ff.den_abs);
      s5_in.c_lo_y = mul_b(s4_ff.box.c_lo_y, s4_ff.den_abs);
      s5_in.c_hi_y = mul_b(s4_ff.box.c_hi_y, s4_ff.den_abs);
   end

   // Stage six: crossing point inside both boxes, never for parallel lines
   assign hit_in = !s5_ff.par
                && in_span(s5_ff.a_lo_x, s5_ff.nx, s5_ff.a_hi_x)
                && in_span(s5_ff.c_lo_x, s5_ff.nx, s5_ff.c_hi_x)
                && in_span(s5_ff.a_lo_y, s5_ff.ny, s5_ff.a_hi_y)
                && in_span(s5_ff.c_lo_y, s5_ff.ny, s5_ff.c_hi_y);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) begin
            v4_ff <= in_valid;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   // Payload, held while the stage stalls
   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_ff <= s4_in;
      end
      if (rdy5) begin
         s5_ff <= s5_in;
      end
      if (rdy6) begin
         hit_ff <= hit_in;
         par_ff <= s5_ff.par;
      end
   end

   assign out_valid = v6_ff;
   assign hit       = hit_ff;
   assign parallel  = par_ff;

endmodule

`default_nettype wire

// ===== rtl/segment_intersection_test_core.sv =====
// Channel    Direction  Word
// req_chan   in         a_x a_y b_x b_y c_x c_y d_x d_y, COORD_WIDTH bits signed each
// rsp_chan   out        hit, parallel, one bit each
//
// Takes one word per cycle unless the response side stalls; six register stages,
// paced by the multipliers (difference by determinant-wide operand in stage five).
// Synchronous reset clears the valid bits only; payload registers are not reset.
// Each stage moves on when it is empty or the next one moves, so a stalled
// response holds its word while earlier stages keep filling; up to six words in flight.
`default_nettype none

module segment_intersection_test_core import sit_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sit_req_if.sink    req_chan,
   sit_rsp_if.source  rsp_chan
);

   seg_type   seg;
   xprod_type xprod;
   logic      x_valid;
   logic      x_ready;

   // Gather the request fields into one word
   assign seg.a_x = req_chan.a_x;
   assign seg.a_y = req_chan.a_y;
   assign seg.b_x = req_chan.b_x;
   assign seg.b_y = req_chan.b_y;
   assign seg.c_x = req_chan.c_x;
   assign seg.c_y = req_chan.c_y;
   assign seg.d_x = req_chan.d_x;
   assign seg.d_y = req_chan.d_y;

   sit_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .seg       (seg),
      .out_valid (x_valid),
      .out_ready (x_ready),
      .xprod     (xprod)
   );

   sit_bound u_bound (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x_valid),
      .in_ready  (x_ready),
      .xprod     (xprod),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .hit       (rsp_chan.hit),
      .parallel  (rsp_chan.parallel)
   );

endmodule

`default_nettype wire

// ===== rtl/sit_checker.sv =====
`default_nettype none

module sit_checker import sit_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_hit,
   input wire logic rsp_parallel
);

   localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

   logic [CNT_W-1:0] pending_ff, pending_in;

   // Track words taken in but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_parallel))
      else $error("response changed while stalled");

   // Parallel lines never report a crossing
   a_par_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_parallel))
      else $error("hit raised together with parallel");

   // No response without a request behind it
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without an outstanding request");

   // The pipeline never holds more words than it has stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more words in flight than pipeline stages");

endmodule

bind segment_intersection_test_core sit_checker u_sit_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_hit      (rsp_chan.hit),
   .rsp_parallel (rsp_chan.parallel)
);

`default_nettype wire

// ===== verif/segment_intersection_test_core_test.sv =====
module segment_intersection_test_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sit_pkg::*;

   localparam int RANDOM_WORDS = 1200;
   localparam int CALM_WORDS   = 200;
   localparam int BACKLOG_AT   = 300;
   localparam int BACKLOG_HOLD = 60;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4 * PIPE_DEPTH;

   // Where a directed row gets its expected verdict from
   typedef enum logic {ANS_TYPED, ANS_PREDICTED} answer_src_type;

   // Shapes of random segment pairs
   typedef enum logic [2:0] {
      PK_WIDE, PK_TINY, PK_CROSSING, PK_PARALLEL, PK_CORNER
   } pair_kind_type;

   typedef struct packed {
      int             ax;
      int             ay;
      int             bx;
      int             by;
      int             cx;
      int             cy;
      int             dx;
      int             dy;
      answer_src_type src;
      logic           hit;
      logic           parallel;
   } pair_row_type;

   typedef struct {
      logic        hit;
      logic        parallel;
      int unsigned tag;
   } verdict_type;

   localparam int N_DIRECTED = 22;

   // Directed pairs: A, B, C, D, then the verdict where it is obvious
   localparam pair_row_type DIRECTED_PAIRS [N_DIRECTED] = '{
      // all points at the origin: degenerate
      '{0, 0, 0, 0, 0, 0, 0, 0, ANS_TYPED, 1'b0, 1'b1},
      // plain X crossing, then with the second segment reversed
      '{0, 0, 10, 10, 0, 10, 10, 0, ANS_TYPED, 1'b1, 1'b0},
      '{0, 0, 10, 10, 10, 0, 0, 10, ANS_TYPED, 1'b1, 1'b0},
      // full-range diagonals cross
      '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, ANS_TYPED, 1'b1, 1'b0},
      '{-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768, ANS_TYPED, 1'b1, 1'b0},
      // full-range horizontals: parallel
      '{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, ANS_TYPED, 1'b0, 1'b1},
      // every field at one extreme
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, ANS_TYPED, 1'b0, 1'b1},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, ANS_TYPED, 1'b0, 1'b1},
      // shared endpoint and a T on an edge both count as a hit
      '{0, 0, 5, 5, 5, 5, 10, 0, ANS_TYPED, 1'b1, 1'b0},
      '{0, 0, 10, 0, 5, 0, 5, 5, ANS_TYPED, 1'b1, 1'b0},
      // lines meet one step past the end of A
      '{0, 0, 10, 0, 11, -5, 11, 5, ANS_TYPED, 1'b0, 1'b0},
      // lines meet outside both boxes
      '{0, 0, 1, 1, 10, 0, 9, 1, ANS_TYPED, 1'b0, 1'b0},
      // collinear overlap, degenerate first segment, identical segments
      '{0, 0, 10, 0, 5, 0, 15, 0, ANS_TYPED, 1'b0, 1'b1},
      '{3, 3, 3, 3, 0, 0, 9, 9, ANS_TYPED, 1'b0, 1'b1},
      '{0, 0, 10, 10, 0, 0, 10, 10, ANS_TYPED, 1'b0, 1'b1},
      // axes at full range cross at the origin
      '{-32768, 0, 32767, 0, 0, -32768, 0, 32767, ANS_TYPED, 1'b1, 1'b0},
      // nearly parallel long segments
      '{0, 0, 32767, 1, 1, 0, 32767, 2, ANS_PREDICTED, 1'b0, 1'b0},
      // alternating bit patterns, then a short segment beside a full-range one
      '{21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845, ANS_PREDICTED, 1'b0, 1'b0},
      '{-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846, ANS_PREDICTED, 1'b0, 1'b0},
      '{1, -1, -1, 1, -32768, 32767, 32767, -32767, ANS_PREDICTED, 1'b0, 1'b0},
      // crossing at a point off the integer grid, inside and outside
      '{0, 0, 3, 1, 1, 0, 2, 1, ANS_PREDICTED, 1'b0, 1'b0},
      '{0, 0, 3, 1, 4, 0, 5, 1, ANS_PREDICTED, 1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   sit_req_if req_chan ();
   sit_rsp_if rsp_chan ();

   segment_intersection_test_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   verdict_type verdicts_due [$];
   int unsigned words_sent     = 0;
   int unsigned words_checked  = 0;
   int unsigned hits_seen      = 0;
   int unsigned parallels_seen = 0;
   int unsigned failures       = 0;
   bit          calm           = 1'b0;
   bit          backlog_done   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Exact bound test: lo <= base + num/den <= hi, den positive
   function automatic logic in_span(longint num, longint den, longint base,
                                    longint p, longint q);
      longint lo;
      longint hi;
      lo = (p < q) ? p : q;
      hi = (p < q) ? q : p;
      return ((lo - base) * den <= num) && (num <= (hi - base) * den);
   endfunction

   // Verdict for one segment pair
   function automatic verdict_type judge_pair(seg_type s);
      longint      ax, ay, cx, cy;
      longint      rx, ry, sx, sy, qx, qy;
      longint      den, tn, nx, ny;
      verdict_type v;
      ax = s.a_x;
      ay = s.a_y;
      cx = s.c_x;
      cy = s.c_y;
      rx = longint'(s.b_x) - ax;
      ry = longint'(s.b_y) - ay;
      sx = longint'(s.d_x) - cx;
      sy = longint'(s.d_y) - cy;
      qx = cx - ax;
      qy = cy - ay;
      den = rx * sy - ry * sx;
      v.tag      = 0;
      v.hit      = 1'b0;
      v.parallel = (den == 0);
      if (den != 0) begin
         tn = qx * sy - qy * sx;
         nx = rx * tn;
         ny = ry * tn;
         // fold the sign into the numerators so the bounds compare one way
         if (den < 0) begin
            den = -den;
            nx  = -nx;
            ny  = -ny;
         end
         v.hit = in_span(nx, den, ax, ax, s.b_x) && in_span(nx, den, ax, cx, s.d_x)
              && in_span(ny, den, ay, ay, s.b_y) && in_span(ny, den, ay, cy, s.d_y);
      end
      return v;
   endfunction

   function automatic int span_int(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic coord_type corner_coord();
      case ($urandom_range(0, 7))
         0:       return coord_type'(-32768);
         1:       return coord_type'(-32767);
         2:       return coord_type'(-1);
         3:       return coord_type'(0);
         4:       return coord_type'(1);
         5:       return coord_type'(32766);
         6:       return coord_type'(32767);
         default: return coord_type'($urandom());
      endcase
   endfunction

   // Build one random pair, biased towards crossings and parallels
   function automatic seg_type make_pair();
      seg_type       s;
      pair_kind_type kind;
      int unsigned   roll;
      int            ax, ay, rx, ry, sx, sy, px, py, n, i;
      roll = $urandom_range(0, 9);
      kind = (roll < 3) ? PK_WIDE : (roll < 4) ? PK_TINY : (roll < 7) ? PK_CROSSING :
             (roll < 9) ? PK_PARALLEL : PK_CORNER;
      s = '0;
      case (kind)
         PK_WIDE: s = {$urandom(), $urandom(), $urandom(), $urandom()};
         PK_TINY: begin
            for (int f = 0; f < 8; f++)
               s[COORD_WIDTH*f +: COORD_WIDTH] = coord_type'(span_int(-8, 8));
         end
         PK_CROSSING: begin
            // put a grid point P on A-B, then run C-D through P
            ax = span_int(-10000, 10000);
            ay = span_int(-10000, 10000);
            rx = span_int(-500, 500);
            ry = span_int(-500, 500);
            n  = span_int(1, 20);
            i  = span_int(0, n);
            px = ax + rx * i;
            py = ay + ry * i;
            sx = span_int(-500, 500);
            sy = span_int(-500, 500);
            s.a_x = coord_type'(ax);
            s.a_y = coord_type'(ay);
            s.b_x = coord_type'(ax + rx * n);
            s.b_y = coord_type'(ay + ry * n);
            i = span_int(0, 10);
            n = span_int(0, 10);
            s.c_x = coord_type'(px - sx * i);
            s.c_y = coord_type'(py - sy * i);
            s.d_x = coord_type'(px + sx * n);
            s.d_y = coord_type'(py + sy * n);
         end
         PK_PARALLEL: begin
            // both directions are multiples of one vector, often on one line
            ax = span_int(-10000, 10000);
            ay = span_int(-10000, 10000);
            rx = span_int(-300, 300);
            ry = span_int(-300, 300);
            n  = span_int(1, 10);
            s.a_x = coord_type'(ax);
            s.a_y = coord_type'(ay);
            s.b_x = coord_type'(ax + rx * n);
            s.b_y = coord_type'(ay + ry * n);
            if ($urandom_range(0, 1) == 0) begin
               i  = span_int(-10, 10);
               px = ax + rx * i;
               py = ay + ry * i;
            end else begin
               px = span_int(-10000, 10000);
               py = span_int(-10000, 10000);
            end
            n = span_int(-10, 10);
            s.c_x = coord_type'(px);
            s.c_y = coord_type'(py);
            s.d_x = coord_type'(px + rx * n);
            s.d_y = coord_type'(py + ry * n);
         end
         PK_CORNER: begin
            for (int f = 0; f < 8; f++)
               s[COORD_WIDTH*f +: COORD_WIDTH] = corner_coord();
         end
         default: s = '0;
      endcase
      return s;
   endfunction

   // Offer one word, record its verdict on acceptance, then maybe pause
   task automatic offer_pair(input seg_type s, input verdict_type want, input int gap_odds);
      int unsigned pause;
      req_chan.valid <= 1'b1;
      req_chan.a_x   <= s.a_x;
      req_chan.a_y   <= s.a_y;
      req_chan.b_x   <= s.b_x;
      req_chan.b_y   <= s.b_y;
      req_chan.c_x   <= s.c_x;
      req_chan.c_y   <= s.c_y;
      req_chan.d_x   <= s.d_x;
      req_chan.d_y   <= s.d_y;
      do @(posedge clock); while (!req_chan.ready);
      want.tag = words_sent;
      verdicts_due.push_back(want);
      words_sent++;
      if (!calm && gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
         req_chan.valid <= 1'b0;
         pause = $urandom_range(1, 9);
         repeat (pause) @(posedge clock);
      end
   endtask

   // Drive the request side: directed table, then random pairs
   initial begin : stimulus
      seg_type      pair;
      verdict_type  want;
      pair_row_type row;
      int           gap_odds;
      req_chan.valid = 1'b0;
      req_chan.a_x   = '0;
      req_chan.a_y   = '0;
      req_chan.b_x   = '0;
      req_chan.b_y   = '0;
      req_chan.c_x   = '0;
      req_chan.c_y   = '0;
      req_chan.d_x   = '0;
      req_chan.d_y   = '0;
      gap_odds       = 4;
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int k = 0; k < N_DIRECTED; k++) begin
         row = DIRECTED_PAIRS[k];
         pair.a_x = coord_type'(row.ax);
         pair.a_y = coord_type'(row.ay);
         pair.b_x = coord_type'(row.bx);
         pair.b_y = coord_type'(row.by);
         pair.c_x = coord_type'(row.cx);
         pair.c_y = coord_type'(row.cy);
         pair.d_x = coord_type'(row.dx);
         pair.d_y = coord_type'(row.dy);
         want = judge_pair(pair);
         if (row.src == ANS_TYPED) begin
            want.hit      = row.hit;
            want.parallel = row.parallel;
         end
         offer_pair(pair, want, gap_odds);
      end

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         // vary the sender's pacing every hundred words, some stretches without gaps
         if (k % 100 == 0)
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(2, 8));
         calm = (k >= RANDOM_WORDS - CALM_WORDS);
         pair = make_pair();
         offer_pair(pair, judge_pair(pair), gap_odds);
      end
      req_chan.valid <= 1'b0;

      // drain, then watch a little longer for stray words
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d segment pairs: %0d crossing, %0d parallel or degenerate.",
               words_checked, hits_seen, parallels_seen);
      $display("Directed extremes and touch cases, random pairs, %0d-cycle response hold.",
               BACKLOG_HOLD);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Pace the response side: random stalls, one long hold, none at the end
   initial begin : rsp_pacing
      int unsigned span;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_chan.ready <= 1'b1;
            span = 1;
         end else if (!backlog_done && words_sent >= BACKLOG_AT) begin
            backlog_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            span = BACKLOG_HOLD;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            span = $urandom_range(1, 9);
         end else begin
            rsp_chan.ready <= 1'b1;
            span = $urandom_range(1, 30);
         end
         repeat (span) @(posedge clock);
      end
   end

   // Compare each response word with the oldest outstanding verdict
   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (verdicts_due.size() == 0) begin
            $error("response word with nothing outstanding: hit=%b parallel=%b",
                   rsp_chan.hit, rsp_chan.parallel);
            failures++;
         end else begin
            want = verdicts_due.pop_front();
            words_checked++;
            if (rsp_chan.hit === 1'b1) hits_seen++;
            if (rsp_chan.parallel === 1'b1) parallels_seen++;
            if (rsp_chan.hit !== want.hit) begin
               $error("pair %0d: hit expected %b, got %b", want.tag, want.hit, rsp_chan.hit);
               failures++;
            end
            if (rsp_chan.parallel !== want.parallel) begin
               $error("pair %0d: parallel expected %b, got %b",
                      want.tag, want.parallel, rsp_chan.parallel);
               failures++;
            end
         end
      end
   end

   // Stop the run if neither side moves a word for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no word moved for %0d cycles, %0d verdicts outstanding.",
               STALL_LIMIT, verdicts_due.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
